>>> rtl/ltm_pkg.sv
// Shared types and codes of the lock table manager.
package ltm_pkg;

  localparam int FUNC_W   = 2;
  localparam int CLIENT_W = 16;
  localparam int KEY_W    = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 32;

  localparam logic [FUNC_W-1:0] FUNC_STAT    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef enum logic [1:0] {
    OP_STAT,
    OP_ACQUIRE,
    OP_RELEASE,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [CLIENT_W-1:0] client;
    logic [KEY_W-1:0]    key;
  } req_t;

  typedef struct packed {
    logic                held;
    logic [CLIENT_W-1:0] holder;
    logic [COUNT_W-1:0]  count;
  } info_t;

  localparam int INFO_W = $bits(info_t);

endpackage

>>> rtl/lock_table_manager.sv
// Lock table manager top level: request queue front end and table back end.
//
// A table of ENTRIES locks keyed by 64-bit lock id answers stat, acquire and
// release requests with one result beat each. A two-deep queue takes request
// beats while the back end works. Entries fill from index 0 upward and are
// never removed, so a fill count stands in for per-entry valid marks and no
// clearing pass runs after reset. The back end scans the key memory one entry
// per cycle through its single read port: a request whose lock sits at index k
// is dequeued, compared with entries 0 to k and resolved; a missing lock is
// compared with every filled entry, and an undefined operation skips the scan.
// A result beat that stalls holds the back end in its resolve cycle.
module lock_table_manager #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ltm_pkg::FUNC_W-1:0]    func,
  input  logic [ltm_pkg::CLIENT_W-1:0]  client,
  input  logic [ltm_pkg::KEY_W-1:0]     lock_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ltm_pkg::STATUS_W-1:0]  status,
  output logic [ltm_pkg::COUNT_W-1:0]   acquire_count
);

  logic          q_valid;
  logic          q_pop;
  ltm_pkg::req_t q_req;

  ltm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func    (func),
    .client  (client),
    .lock_id (lock_id),
    .q_valid (q_valid),
    .q_req   (q_req),
    .q_pop   (q_pop)
  );

  ltm_back #(
    .ENTRIES(ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_req        (q_req),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .acquire_count(acquire_count)
  );

endmodule

>>> rtl/ltm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ltm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ltm_front.sv
// Request front end: accepts beats, decodes the operation, queues them for the back end.
module ltm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ltm_pkg::FUNC_W-1:0]    func,
  input  logic [ltm_pkg::CLIENT_W-1:0]  client,
  input  logic [ltm_pkg::KEY_W-1:0]     lock_id,
  output logic                          q_valid,
  output ltm_pkg::req_t                 q_req,
  input  logic                          q_pop
);

  ltm_pkg::req_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  ltm_pkg::op_t  op;
  logic          push;

  always_comb begin
    case (func)
      ltm_pkg::FUNC_STAT:    op = ltm_pkg::OP_STAT;
      ltm_pkg::FUNC_ACQUIRE: op = ltm_pkg::OP_ACQUIRE;
      ltm_pkg::FUNC_RELEASE: op = ltm_pkg::OP_RELEASE;
      default:               op = ltm_pkg::OP_NONE;
    endcase
  end

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_req    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{op: op, client: client, key: lock_id};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, q_pop && q_valid})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/ltm_back.sv
// Lock table back end: scans the table memories, applies the operation, holds the result.
module ltm_back #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  ltm_pkg::req_t                  q_req,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ltm_pkg::STATUS_W-1:0]   status,
  output logic [ltm_pkg::COUNT_W-1:0]    acquire_count
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE
  } state_t;

  state_t                        state;
  ltm_pkg::req_t                 cur;
  logic [IDX_W-1:0]              cmp_idx;
  logic [CNT_W-1:0]              fill;
  logic                          hit;
  ltm_pkg::info_t                h_info;

  logic [IDX_W-1:0]              rd_addr;
  logic [ltm_pkg::KEY_W-1:0]     key_rdata;
  logic [ltm_pkg::INFO_W-1:0]    info_rdata;
  logic                          key_we;
  logic                          info_we;
  logic [IDX_W-1:0]              info_waddr;
  ltm_pkg::info_t                info_wdata;
  logic [ltm_pkg::STATUS_W-1:0]  res_status;
  logic [ltm_pkg::COUNT_W-1:0]   res_count;
  logic                          fill_inc;
  logic                          match;
  logic                          last;
  logic                          out_free;
  logic                          commit;
  logic                          full;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign match    = (key_rdata == cur.key);
  assign last     = ((CNT_W'(cmp_idx) + CNT_W'(1)) == fill);
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == S_RESOLVE) && out_free;
  assign full     = (fill == CNT_W'(ENTRIES));
  assign rd_addr  = (state == S_SCAN) ? IDX_W'(cmp_idx + IDX_W'(1)) : '0;

  // Work out the result and the table update from the registered lookup.
  always_comb begin
    res_status = ltm_pkg::ST_OK;
    res_count  = '0;
    key_we     = 1'b0;
    info_we    = 1'b0;
    fill_inc   = 1'b0;
    info_waddr = cmp_idx;
    info_wdata = h_info;
    case (cur.op)
      ltm_pkg::OP_STAT: begin
        if (hit) begin
          res_count = h_info.count;
        end
      end
      ltm_pkg::OP_ACQUIRE: begin
        if (hit) begin
          if (h_info.held) begin
            res_status = ltm_pkg::ST_BUSY;
          end else begin
            info_we           = 1'b1;
            info_wdata.held   = 1'b1;
            info_wdata.holder = cur.client;
            info_wdata.count  = (h_info.count == '1) ? h_info.count
                                                     : h_info.count + 32'd1;
          end
        end else if (full) begin
          res_status = ltm_pkg::ST_FULL;
        end else begin
          key_we            = 1'b1;
          info_we           = 1'b1;
          fill_inc          = 1'b1;
          info_waddr        = fill[IDX_W-1:0];
          info_wdata.held   = 1'b1;
          info_wdata.holder = cur.client;
          info_wdata.count  = 32'd1;
        end
      end
      ltm_pkg::OP_RELEASE: begin
        if (hit && h_info.held && (h_info.holder == cur.client)) begin
          info_we         = 1'b1;
          info_wdata.held = 1'b0;
        end else begin
          res_status = ltm_pkg::ST_REFUSED;
        end
      end
      default: begin
        res_status = ltm_pkg::ST_OK;
      end
    endcase
  end

  ltm_ram #(
    .WIDTH(ltm_pkg::KEY_W),
    .DEPTH(ENTRIES)
  ) u_key_ram (
    .clk  (clk),
    .we   (commit && key_we),
    .waddr(fill[IDX_W-1:0]),
    .wdata(cur.key),
    .raddr(rd_addr),
    .rdata(key_rdata)
  );

  ltm_ram #(
    .WIDTH(ltm_pkg::INFO_W),
    .DEPTH(ENTRIES)
  ) u_info_ram (
    .clk  (clk),
    .we   (commit && info_we),
    .waddr(info_waddr),
    .wdata(info_wdata),
    .raddr(rd_addr),
    .rdata(info_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a new beat, or drop the one just taken.
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur     <= q_req;
            hit     <= 1'b0;
            cmp_idx <= '0;
            // Skip the scan when nothing can match.
            if (q_req.op == ltm_pkg::OP_NONE || fill == '0) begin
              state <= S_RESOLVE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            hit    <= 1'b1;
            h_info <= ltm_pkg::info_t'(info_rdata);
            state  <= S_RESOLVE;
          end else if (last) begin
            state <= S_RESOLVE;
          end else begin
            cmp_idx <= IDX_W'(cmp_idx + IDX_W'(1));
          end
        end
        S_RESOLVE: begin
          if (out_free) begin
            status        <= res_status;
            acquire_count <= res_count;
            if (fill_inc) begin
              fill <= CNT_W'(fill + CNT_W'(1));
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
